// File: hw/rtl/assert_macros.svh
// Assertion helpers. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define NWTF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("%m: property failed");

`define NWTF_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define NWTF_ASSERT(label, clk, rst_n, prop)

`define NWTF_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/nwtf_pkg.sv
package nwtf_pkg;

	localparam int MAX_TEXT_UNITS = 65536;
	localparam int UNIT_W = 16;
	localparam int POS_W = 16;
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [POS_W-1:0] POS_CAP =
		((MAX_TEXT_UNITS - 1) < 65535) ? POS_W'(MAX_TEXT_UNITS - 1) : {POS_W{1'b1}};

	// register indexes on the config port
	localparam logic [CFG_ADDR_W-1:0] CFG_MIN_KEPT_LENGTH = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_LIMIT = CFG_ADDR_W'(1);

	localparam logic [7:0] RESET_MIN_KEPT_LENGTH = 8'd4;
	localparam logic [3:0] RESET_REPEAT_LIMIT = 4'd3;

	localparam int NUM_MARKS = 22;
	localparam logic [UNIT_W-1:0] PUNCT_MARKS [NUM_MARKS] = '{
		16'h002C, 16'h002E, 16'h0021, 16'h003F, 16'h003B, 16'h003A, 16'h0022, 16'h002D,
		16'h002F, 16'h002B, 16'h0028, 16'h0029, 16'h007B, 16'h007D, 16'h005B, 16'h005D,
		16'h005C, 16'h0060, 16'h00B4, 16'h005F, 16'h005E, 16'h007E
	};

	typedef struct packed {
		logic nul;
		logic space;
		logic punct;
		logic unwanted;
		logic bom_low;
		logic is_p;
	} unit_class_t;

endpackage

// File: hw/rtl/nwtf_if.sv
interface nwtf_text_if;
	import nwtf_pkg::*;
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;
	logic              last_unit;
	modport source (output valid, output code_unit, output last_unit, input ready);
	modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

interface nwtf_word_if;
	import nwtf_pkg::*;
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] word_start;
	logic [POS_W-1:0] word_length;
	modport source (output valid, output word_start, output word_length, input ready);
	modport sink (input valid, input word_start, input word_length, output ready);
endinterface

interface nwtf_cfg_if;
	import nwtf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

// File: hw/rtl/nwtf_classify.sv
module nwtf_classify (
	input  logic [nwtf_pkg::UNIT_W-1:0] code,
	output nwtf_pkg::unit_class_t       cls
);
	import nwtf_pkg::*;

	logic [7:0] hi;
	logic [7:0] lo;
	logic       punct_hit;

	assign hi = code[15:8];
	assign lo = code[7:0];

	always_comb begin
		punct_hit = 1'b0;
		for (int k = 0; k < NUM_MARKS; k++) begin
			if (code == PUNCT_MARKS[k]) begin
				punct_hit = 1'b1;
			end
		end
	end

	always_comb begin
		cls.nul      = (code == 16'h0000);
		cls.space    = (code == 16'h0020) || (code == 16'h0009) ||
			(code == 16'h000A) || (code == 16'h000D);
		cls.punct    = punct_hit;
		cls.unwanted = (hi > 8'h05) || ((hi == 8'h00) && (lo < 8'h41)) ||
			((hi == 8'h00) && (lo >= 8'h7B) && (lo < 8'hC0)) ||
			((hi == 8'h03) && (lo < 8'h80));
		cls.bom_low  = (lo == 8'hFF) || (lo == 8'hFE);
		cls.is_p     = ((code | 16'h0020) == 16'h0070);
	end

endmodule

// File: hw/rtl/nwtf_core.sv
`include "assert_macros.svh"

module nwtf_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [nwtf_pkg::UNIT_W-1:0] code,
	input  logic                        last,
	input  nwtf_pkg::unit_class_t       cls,
	input  logic [7:0]                  min_len,
	input  logic [3:0]                  repeat_lim,
	output logic                        emit,
	output logic [nwtf_pkg::POS_W-1:0]  out_start,
	output logic [nwtf_pkg::POS_W-1:0]  out_length
);
	import nwtf_pkg::*;

	logic [POS_W-1:0]  position_q;
	logic [POS_W-1:0]  pstart_q;
	logic [POS_W-1:0]  plen_q;
	logic [UNIT_W-1:0] prev_q;
	logic [3:0]        run_q;
	logic              noisy_q;
	logic              url_q;
	logic [UNIT_W-1:0] recent_q [3];
	logic              stopped_q;

	logic              short_text;
	logic              bom;
	logic              breaker;
	logic [7:0]        min_eff;
	logic              same;
	logic [3:0]        run_nx;
	logic              noisy_l;
	logic              url_l;
	logic [POS_W-1:0]  start_l;
	logic [POS_W-1:0]  plen_l;

	always_comb begin
		short_text = last && (position_q <= POS_W'(1));
		bom        = (position_q == '0) && cls.bom_low;
		breaker    = cls.nul || cls.space || cls.punct;
		min_eff    = (min_len == 8'd0) ? 8'd1 : min_len;
		same       = (code == prev_q) ||
			({1'b0, code} == ({1'b0, prev_q} + 17'h00020)) ||
			((prev_q >= 16'h0020) && (code == (prev_q - 16'h0020)));
		run_nx     = same ? ((run_q == 4'hF) ? run_q : run_q + 4'd1) : 4'd1;
		noisy_l    = noisy_q || (run_nx >= repeat_lim) || cls.unwanted;
		url_l      = url_q || (cls.is_p &&
			((recent_q[0] | 16'h0020) == 16'h0074) &&
			((recent_q[1] | 16'h0020) == 16'h0074) &&
			((recent_q[2] | 16'h0020) == 16'h0068));
		start_l    = (plen_q == '0) ? position_q : pstart_q;
		plen_l     = (plen_q < POS_CAP) ? plen_q + POS_W'(1) : plen_q;
	end

	always_comb begin
		emit       = 1'b0;
		out_start  = pstart_q;
		out_length = plen_q;
		if (!stopped_q && !bom) begin
			if (breaker) begin
				emit = (plen_q >= {8'd0, min_eff}) && !noisy_q && !url_q && !short_text;
			end else if (last) begin
				emit       = (plen_l >= {8'd0, min_eff}) && !noisy_l && !url_l &&
					!short_text;
				out_start  = start_l;
				out_length = plen_l;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= '0;
			pstart_q    <= '0;
			plen_q      <= '0;
			prev_q      <= '0;
			run_q       <= '0;
			noisy_q     <= 1'b0;
			url_q       <= 1'b0;
			recent_q[0] <= '0;
			recent_q[1] <= '0;
			recent_q[2] <= '0;
			stopped_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				position_q  <= '0;
				pstart_q    <= '0;
				plen_q      <= '0;
				prev_q      <= '0;
				run_q       <= '0;
				noisy_q     <= 1'b0;
				url_q       <= 1'b0;
				recent_q[0] <= '0;
				recent_q[1] <= '0;
				recent_q[2] <= '0;
				stopped_q   <= 1'b0;
			end else if (!stopped_q) begin
				if (!bom) begin
					if (breaker) begin
						plen_q    <= '0;
						noisy_q   <= 1'b0;
						stopped_q <= cls.nul;
						if (cls.space) begin
							url_q <= 1'b0;
						end
					end else begin
						if (!same) begin
							prev_q <= code;
						end
						run_q    <= run_nx;
						noisy_q  <= noisy_l;
						url_q    <= url_l;
						pstart_q <= start_l;
						plen_q   <= plen_l;
					end
					recent_q[2] <= recent_q[1];
					recent_q[1] <= recent_q[0];
					recent_q[0] <= code;
				end
				if (position_q < POS_CAP) begin
					position_q <= position_q + POS_W'(1);
				end
			end
		end
	end

	`NWTF_ASSERT(a_stopped_no_pending, clk, arst_n, stopped_q |-> (plen_q == '0))
	`NWTF_ASSERT(a_last_clears, clk, arst_n,
		(step && last) |=> ((position_q == '0) && !stopped_q && (plen_q == '0)))
	`NWTF_NEVER(n_empty_word, clk, arst_n, step && emit && (out_length == '0))

endmodule

// File: hw/rtl/noisy_word_token_filter.sv
// Word filter over a UTF-16 text stream. One code unit is taken per cycle with no
// bubbles while the output is not stalled. Each unit is captured in an input register,
// then classified and used to update the text state at the edge where it advances. A
// kept word (start, length) is loaded into the output register at that same edge, so a
// result passes the input register and then the output register after the unit that
// ends the word is accepted. The state update sets the rate of one unit per cycle while
// the output is not stalled; output back-pressure stalls the input stage directly.
// Configuration writes are always accepted and should be made while no text is in flight.
module noisy_word_token_filter (
	input logic        clk,
	input logic        arst_n,
	nwtf_text_if.sink  text,
	nwtf_word_if.source words,
	nwtf_cfg_if.sink   cfg
);
	import nwtf_pkg::*;

	logic              valid_s1;
	logic [UNIT_W-1:0] code_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic [POS_W-1:0]  out_start_q;
	logic [POS_W-1:0]  out_length_q;

	logic [7:0]        min_len_q;
	logic [3:0]        repeat_q;

	logic              advance;
	logic              step;
	unit_class_t       cls;
	logic              emit;
	logic [POS_W-1:0]  res_start;
	logic [POS_W-1:0]  res_length;

	assign advance    = !out_valid_q || words.ready;
	assign step       = valid_s1 && advance;
	assign text.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	assign words.valid       = out_valid_q;
	assign words.word_start  = out_start_q;
	assign words.word_length = out_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= RESET_MIN_KEPT_LENGTH;
			repeat_q  <= RESET_REPEAT_LIMIT;
		end else if (cfg.valid) begin
			if (cfg.addr == CFG_MIN_KEPT_LENGTH) begin
				min_len_q <= cfg.data[7:0];
			end else if (cfg.addr == CFG_REPEAT_LIMIT) begin
				repeat_q <= cfg.data[3:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			code_s1 <= text.code_unit;
			last_s1 <= text.last_unit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_start_q  <= res_start;
			out_length_q <= res_length;
		end
	end

	nwtf_classify u_classify (
		.code (code_s1),
		.cls  (cls)
	);

	nwtf_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.code       (code_s1),
		.last       (last_s1),
		.cls        (cls),
		.min_len    (min_len_q),
		.repeat_lim (repeat_q),
		.emit       (emit),
		.out_start  (res_start),
		.out_length (res_length)
	);

endmodule
